// ===== hdl/rsd_pkg.sv =====
// Shared types and constants of the run-length sprite pixel decoder.
package rsd_pkg;

    localparam int WORD_W   = 16;
    localparam int COUNT_W  = 15;
    localparam int COL_W    = 16;
    localparam int ROW_W    = 17;
    localparam int COORD_W  = 18;
    localparam int CFG_IDX_W = 3;
    localparam int LIT_FLAG_BIT = 15;

    // Divider: dividend is column plus a 15-bit skip, one quotient bit a step
    localparam int DIV_W     = 17;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    // Register indexes of the write port
    localparam logic [CFG_IDX_W-1:0] CFG_POS_X         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_Y         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT = 3'd5;

    // Register reset values
    localparam logic [WORD_W-1:0] RST_SPRITE_WIDTH  = 16'd1;
    localparam logic [WORD_W-1:0] RST_SPRITE_HEIGHT = 16'd1;
    localparam logic [WORD_W-1:0] RST_TARGET_WIDTH  = 16'd320;
    localparam logic [WORD_W-1:0] RST_TARGET_HEIGHT = 16'd240;

    typedef struct packed {
        logic               start;
        logic [DIV_W-1:0]   dividend;
        logic [WORD_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [DIV_W-1:0]   quotient;
        logic [WORD_W-1:0]  remainder;
    } div_rsp_t;

endpackage

// ===== hdl/rsd_if.sv =====
// Valid/ready channel interfaces for code words and pixel results.
interface rsd_code_if
    import rsd_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] code_word;

    modport source (output valid, output code_word, input ready);
    modport sink   (input valid, input code_word, output ready);
endinterface

interface rsd_pixel_if
    import rsd_pkg::*;
    ;
    logic                      valid;
    logic                      ready;
    logic                      draw;
    logic signed [COORD_W-1:0] screen_x;
    logic signed [COORD_W-1:0] screen_y;
    logic [WORD_W-1:0]         color;
    logic                      frame_end;

    modport source (output valid, output draw, output screen_x, output screen_y,
                    output color, output frame_end, input ready);
    modport sink   (input valid, input draw, input screen_x, input screen_y,
                    input color, input frame_end, output ready);
endinterface

// ===== hdl/rsd_divider.sv =====
// Restoring divider, one quotient bit per cycle, with a fast path for small dividends.
module rsd_divider
    import rsd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] count_reg, count_next;
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     quot_reg, quot_next;
    logic [WORD_W-1:0]    divisor_reg, divisor_next;
    logic [DIV_W-1:0]     trial;
    logic                 fits;

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        count_next   = count_reg;
        rem_next     = rem_reg;
        quot_next    = quot_reg;
        divisor_next = divisor_reg;
        // shift the next dividend bit into the partial remainder
        trial = {rem_reg[DIV_W-2:0], quot_reg[DIV_W-1]};
        fits  = trial >= {1'b0, divisor_reg};

        if (busy_reg)
        begin
            rem_next  = fits ? (trial - {1'b0, divisor_reg}) : trial;
            quot_next = {quot_reg[DIV_W-2:0], fits};
            if (count_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                count_next = count_reg - 1'b1;
            end
        end
        else if (req.start)
        begin
            divisor_next = req.divisor;
            if (req.dividend < {1'b0, req.divisor})
            begin
                // quotient is zero: finish at once
                quot_next = '0;
                rem_next  = req.dividend;
                done_next = 1'b1;
            end
            else
            begin
                quot_next  = req.dividend;
                rem_next   = '0;
                count_next = DIV_CNT_W'(DIV_W - 1);
                busy_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        quot_reg    <= quot_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quot_reg;
    assign rsp.remainder = rem_reg[WORD_W-1:0];

endmodule

// ===== hdl/rle_sprite_pixel_decoder_unit.sv =====
// Top level of the run-length sprite pixel decoder: word sequencer, clipping and result register.
//
// Takes one 16-bit word of a run-length coded sprite frame per transfer on the code channel
// and returns exactly one result per word on the pixel channel. A literal colour word, and a
// header that announces literals, goes straight into the result register. A skip header goes
// through the restoring divider, which splits the new column by the sprite width into rows and a
// remainder: its fast path serves a skip that stays inside the current row, otherwise it works
// out the quotient one bit at a time. Meanwhile the code
// channel is held off. The result register parts the two channels: a new word is taken while
// the previous result is being transferred out. Literal pixels outside the render target are
// still reported, with draw low. Configuration writes are meant for an idle block.
module rle_sprite_pixel_decoder_unit
    import rsd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    rsd_code_if.sink             code,
    rsd_pixel_if.source          pixel
);

    typedef enum logic {ST_IDLE, ST_DIVIDE} state_t;

    state_t state_reg, state_next;

    // configuration registers
    logic signed [WORD_W-1:0] pos_x_reg, pos_y_reg;
    logic [WORD_W-1:0]        sprite_width_reg, sprite_height_reg;
    logic [WORD_W-1:0]        target_width_reg, target_height_reg;

    // decode position
    logic [COUNT_W-1:0] literals_left_reg, literals_left_next;
    logic [COL_W-1:0]   column_reg, column_next;
    logic [ROW_W-1:0]   row_reg, row_next;

    // result register
    logic                      out_valid_reg, out_valid_next;
    logic                      out_draw_reg, out_draw_next;
    logic signed [COORD_W-1:0] out_x_reg, out_x_next;
    logic signed [COORD_W-1:0] out_y_reg, out_y_next;
    logic [WORD_W-1:0]         out_color_reg, out_color_next;
    logic                      out_fend_reg, out_fend_next;

    div_req_t div_req;
    div_rsp_t div_rsp;
    logic     div_start;

    logic                      accept;
    logic                      out_take;
    logic [WORD_W-1:0]         eff_width;
    logic [COUNT_W-1:0]        count;
    logic                      row_done;
    logic signed [COORD_W-1:0] pix_x;
    logic signed [COORD_W:0]   pix_y;
    logic                      visible;
    logic [COL_W:0]            col_inc;
    logic                      col_wrap;
    logic [ROW_W-1:0]          row_lit;
    logic [ROW_W-1:0]          row_sum;

    rsd_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign code.ready = (state_reg == ST_IDLE) && (!out_valid_reg || pixel.ready);
    assign accept     = code.valid && code.ready;
    assign out_take   = out_valid_reg && pixel.ready;

    // a zero width behaves as a width of one
    assign eff_width = (sprite_width_reg == '0) ? WORD_W'(1) : sprite_width_reg;
    assign count     = code.code_word[COUNT_W-1:0];
    assign row_done  = row_reg >= {1'b0, sprite_height_reg};

    // literal pixel position and clip test
    assign pix_x   = COORD_W'(pos_x_reg) + $signed({2'b00, column_reg});
    assign pix_y   = (COORD_W+1)'(pos_y_reg) + $signed({2'b00, row_reg});
    assign visible = !pix_x[COORD_W-1] && (pix_x[COORD_W-2:0] < {1'b0, target_width_reg})
                  && !pix_y[COORD_W] && (pix_y[COORD_W-1:0] < {2'b00, target_height_reg});

    // column step after a literal, wrapping into the next row
    assign col_inc  = {1'b0, column_reg} + 1'b1;
    assign col_wrap = col_inc >= {1'b0, eff_width};
    assign row_lit  = col_wrap ? (row_reg + 1'b1) : row_reg;

    // row after a skip: add the rows the divider counted
    assign row_sum = row_reg + div_rsp.quotient[ROW_W-1:0];

    // divider request: start pulse, column plus skip as dividend, effective width as divisor
    assign div_req = {div_start, DIV_W'({1'b0, column_reg} + {2'b00, count}), eff_width};

    always_comb
    begin
        state_next         = state_reg;
        literals_left_next = literals_left_reg;
        column_next        = column_reg;
        row_next           = row_reg;
        out_valid_next     = out_valid_reg && !out_take;
        out_draw_next      = out_draw_reg;
        out_x_next         = out_x_reg;
        out_y_next         = out_y_reg;
        out_color_next     = out_color_reg;
        out_fend_next      = out_fend_reg;
        div_start          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (literals_left_reg == '0)
                    begin
                        if (code.code_word[LIT_FLAG_BIT])
                        begin
                            // literal header: arm the count; an empty chunk ends here
                            literals_left_next = count;
                            out_valid_next     = 1'b1;
                            out_draw_next      = 1'b0;
                            out_x_next         = '0;
                            out_y_next         = '0;
                            out_color_next     = '0;
                            out_fend_next      = (count == '0) && row_done;
                            if ((count == '0) && row_done)
                            begin
                                column_next = '0;
                                row_next    = '0;
                            end
                        end
                        else
                        begin
                            // skip header: hand the new column to the divider
                            div_start  = 1'b1;
                            state_next = ST_DIVIDE;
                        end
                    end
                    else
                    begin
                        out_valid_next     = 1'b1;
                        out_draw_next      = visible;
                        out_x_next         = pix_x;
                        out_y_next         = pix_y[COORD_W-1:0];
                        out_color_next     = code.code_word;
                        literals_left_next = literals_left_reg - 1'b1;
                        column_next        = col_wrap ? '0 : col_inc[COL_W-1:0];
                        row_next           = row_lit;
                        out_fend_next      = 1'b0;
                        // last literal of the chunk: check for frame end
                        if ((literals_left_reg == COUNT_W'(1))
                            && (row_lit >= {1'b0, sprite_height_reg}))
                        begin
                            out_fend_next = 1'b1;
                            column_next   = '0;
                            row_next      = '0;
                        end
                    end
                end
            end

            ST_DIVIDE:
            begin
                if (div_rsp.done)
                begin
                    out_valid_next = 1'b1;
                    out_draw_next  = 1'b0;
                    out_x_next     = '0;
                    out_y_next     = '0;
                    out_color_next = '0;
                    if (row_sum >= {1'b0, sprite_height_reg})
                    begin
                        out_fend_next = 1'b1;
                        column_next   = '0;
                        row_next      = '0;
                    end
                    else
                    begin
                        out_fend_next = 1'b0;
                        column_next   = div_rsp.remainder;
                        row_next      = row_sum;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            literals_left_reg <= '0;
            column_reg        <= '0;
            row_reg           <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            literals_left_reg <= literals_left_next;
            column_reg        <= column_next;
            row_reg           <= row_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // result payload: no reset needed
    always_ff @(posedge clk)
    begin
        out_draw_reg  <= out_draw_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_color_reg <= out_color_next;
        out_fend_reg  <= out_fend_next;
    end

    // configuration writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg         <= '0;
            pos_y_reg         <= '0;
            sprite_width_reg  <= RST_SPRITE_WIDTH;
            sprite_height_reg <= RST_SPRITE_HEIGHT;
            target_width_reg  <= RST_TARGET_WIDTH;
            target_height_reg <= RST_TARGET_HEIGHT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_POS_X:         pos_x_reg         <= $signed(cfg_data);
                CFG_POS_Y:         pos_y_reg         <= $signed(cfg_data);
                CFG_SPRITE_WIDTH:  sprite_width_reg  <= cfg_data;
                CFG_SPRITE_HEIGHT: sprite_height_reg <= cfg_data;
                CFG_TARGET_WIDTH:  target_width_reg  <= cfg_data;
                CFG_TARGET_HEIGHT: target_height_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign pixel.valid     = out_valid_reg;
    assign pixel.draw      = out_draw_reg;
    assign pixel.screen_x  = out_x_reg;
    assign pixel.screen_y  = out_y_reg;
    assign pixel.color     = out_color_reg;
    assign pixel.frame_end = out_fend_reg;

endmodule

// ===== hdl/rsd_checker.sv =====
// Port-level checks of the sprite pixel decoder and their bind to the top level.
module rsd_checker
    import rsd_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      code_valid,
    input logic                      code_ready,
    input logic                      pixel_valid,
    input logic                      pixel_ready,
    input logic                      pixel_draw,
    input logic signed [COORD_W-1:0] pixel_x,
    input logic signed [COORD_W-1:0] pixel_y,
    input logic [WORD_W-1:0]         pixel_color,
    input logic                      pixel_fend
);

    // a held result keeps its payload
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_ready |=> pixel_valid && $stable(pixel_draw)
            && $stable(pixel_x) && $stable(pixel_y) && $stable(pixel_color)
            && $stable(pixel_fend))
        else $error("result changed while stalled");

    // no new word while the result register is blocked
    a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_ready |-> !code_ready)
        else $error("code word taken while result is stalled");

    // a drawn pixel lies inside a 16-bit target
    a_draw_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_draw |-> (pixel_x[COORD_W-1:WORD_W] == 2'b00)
            && (pixel_y[COORD_W-1:WORD_W] == 2'b00))
        else $error("drawn pixel outside target range");

    // an empty, idle block produces no result unless a word is transferred in
    a_no_result_from_nothing: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel_valid && code_ready && !code_valid |=> !pixel_valid)
        else $error("result appeared without a code word");

    // no result straight after reset
    a_idle_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !pixel_valid)
        else $error("result valid straight after reset");

endmodule

bind rle_sprite_pixel_decoder_unit rsd_checker u_rsd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .code_valid  (code.valid),
    .code_ready  (code.ready),
    .pixel_valid (pixel.valid),
    .pixel_ready (pixel.ready),
    .pixel_draw  (pixel.draw),
    .pixel_x     (pixel.screen_x),
    .pixel_y     (pixel.screen_y),
    .pixel_color (pixel.color),
    .pixel_fend  (pixel.frame_end)
);
